@@ sv/hashed_identity_registry_assert.svh @@
// Assertion macros shared by the hashed identity registry RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef HASHED_IDENTITY_REGISTRY_ASSERT_SVH
`define HASHED_IDENTITY_REGISTRY_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define HIR_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define HIR_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define HIR_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)
`define HIR_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

@@ sv/hir_pkg.sv @@
// Shared types, codes and constants of the hashed identity registry.
// No dependencies; imported by every module of the block but hir_ram.
`default_nettype none

package hir_pkg;

    // Field widths
    localparam int ID_W        = 64;
    localparam int CLASS_W     = 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 4;
    localparam int NUMBER_W    = 64;
    localparam int COUNT_W     = 11;
    localparam int CFG_W       = 8;
    localparam int CFG_INDEX_W = 1;

    // Stream packing
    localparam int S_TDATA_W = ((ID_W + CLASS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUMBER_W + 2 * COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - NUMBER_W - 2 * COUNT_W;

    localparam int DEFAULT_TABLE_SLOTS = 1024;

    // Hash constants
    localparam logic [ID_W-1:0] MIX_ID    = 64'h9E3779B185EBCA87;
    localparam logic [ID_W-1:0] MIX_CLASS = 64'hC2B2AE3D27D4EB4F;
    localparam int FOLD_SHIFT = 32;
    localparam int HALF_W     = 32;

    // Register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_LOWEST  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_HIGHEST = 1'd1;
    localparam logic [CFG_W-1:0] TYPE_LOWEST_RESET  = 8'd0;
    localparam logic [CFG_W-1:0] TYPE_HIGHEST_RESET = 8'd7;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_RESOLVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETIRE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_EXISTING        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOCATED       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_RETIRED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_RETIRED         = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND       = 4'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID         = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FULL            = 4'd6;
    localparam logic [STATUS_W-1:0] ST_COUNTER_OUT     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_CLEARED         = 4'd8;

    // One table slot as stored in the slot memory
    typedef struct packed {
        logic                used;
        logic                retired;
        logic [NUMBER_W-1:0] number;
        logic [CLASS_W-1:0]  cls;
        logic [ID_W-1:0]     ident;
    } hir_entry_t;

    localparam int ENTRY_W = $bits(hir_entry_t);

    // Request handed from the stream side to the controller
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    ident;
        logic [CLASS_W-1:0] cls;
        logic               key_ok;
    } hir_req_t;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUMBER_W-1:0] number;
        logic [COUNT_W-1:0]  held;
        logic [COUNT_W-1:0]  active;
    } hir_res_t;

endpackage

`default_nettype wire

@@ sv/hashed_identity_registry.sv @@
// Top level of the hashed identity registry: stream ports, key check,
// type range registers and output register. Depends on hir_pkg, hir_ram,
// hir_hash and hir_ctrl.
//
//   port group  dir  handshake          payload
//   s_*         in   s_tvalid/s_tready  tuser: kind; tdata: identity, object_class
//   m_*         out  m_tvalid/m_tready  tuser: status; tdata: entity_number, counts
//   cfg_*       in   cfg_we             cfg_index selects register, cfg_data value
//
// Resolve and retire are accepted, wait on the hash (four steps on a shared
// 32x32 multiplier, then the home slot read), check one probed slot per cycle
// along the linear probe run from the home slot, and then give the result.
// Clear and reset each run a clearing pass over every slot of the slot memory;
// after reset s_tready stays low for the whole pass.
// Invalid keys and the unused kind are answered without a hash or probe. The
// output register lets a request be taken while the previous result waits on
// m_tready.
`default_nettype none

`include "hashed_identity_registry_assert.svh"

module hashed_identity_registry import hir_pkg::*; #(
    parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // identity[63:0], object_class[71:64]
    input  wire logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // entity_number[63:0],
                                                   // identities_held[74:64],
                                                   // identities_active[85:75], zero
    output logic [STATUS_W-1:0]         m_tuser,   // status[3:0]
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic [CFG_W-1:0]  type_lowest_reg, type_lowest_next;
    logic [CFG_W-1:0]  type_highest_reg, type_highest_next;
    logic              m_tvalid_reg, m_tvalid_next;
    hir_res_t          out_reg, out_next;

    hir_req_t          req;
    logic              req_ready;
    logic              hash_start, hash_done;
    logic [IDX_W-1:0]  hash_home;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    hir_entry_t        ram_wdata, ram_rdata;
    logic              res_valid, res_ready;
    hir_res_t          res;

    // Unpack the request and check the key against the type range
    always_comb
    begin
        req.kind   = s_tuser;
        req.ident  = s_tdata[ID_W-1:0];
        req.cls    = s_tdata[ID_W +: CLASS_W];
        req.key_ok = (req.ident != '0) && (req.cls >= type_lowest_reg)
                     && (req.cls <= type_highest_reg);
    end

    // Type range registers
    always_comb
    begin
        type_lowest_next  = type_lowest_reg;
        type_highest_next = type_highest_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TYPE_LOWEST:  type_lowest_next  = cfg_data;
                CFG_TYPE_HIGHEST: type_highest_next = cfg_data;
                default:          type_lowest_next  = type_lowest_reg;
            endcase
        end
    end

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_lowest_reg  <= TYPE_LOWEST_RESET;
            type_highest_reg <= TYPE_HIGHEST_RESET;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            type_lowest_reg  <= type_lowest_next;
            type_highest_reg <= type_highest_next;
            m_tvalid_reg     <= m_tvalid_next;
            out_reg          <= out_next;
        end
    end

    assign s_tready = req_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.active, out_reg.held, out_reg.number};

    hir_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .ident (req.ident),
        .cls   (req.cls),
        .done  (hash_done),
        .home  (hash_home)
    );

    hir_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hir_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req        (req),
        .req_ready  (req_ready),
        .hash_start (hash_start),
        .hash_done  (hash_done),
        .hash_home  (hash_home),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // One request at a time: the controller is busy right after taking one
    `HIR_ASSERT(a_one_in_flight, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready,
        "second request taken while one is in flight")

endmodule

`default_nettype wire

@@ sv/hir_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; holds the slot table.
`default_nettype none

module hir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/hir_hash.sv @@
// Home slot hash: multiply-xor of identity and class, folded to a slot index.
// Depends on hir_pkg; one shared 32x32 multiplier for the partial products.
`default_nettype none

`include "hashed_identity_registry_assert.svh"

module hir_hash import hir_pkg::*; #(
    parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [ID_W-1:0]                ident,
    input  wire logic [CLASS_W-1:0]             cls,
    output logic                                done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      home
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    typedef enum logic [2:0] {
        H_IDLE,
        H_LOW,
        H_CROSS_A,
        H_CROSS_B,
        H_FOLD
    } hstate_t;

    hstate_t              state_reg, state_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     home_reg, home_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic [ID_W-1:0]      acc_reg, acc_next;
    logic [ID_W-1:0]      cacc_reg, cacc_next;

    logic [HALF_W-1:0]    op_a, op_b;
    logic [2*HALF_W-1:0]  prod;
    logic [ID_W-1:0]      cls_prod;
    logic [ID_W-1:0]      mixed;
    logic [ID_W-1:0]      folded;

    // Shared multiplier: low x low, high x low, low x high of identity and mix
    always_comb
    begin
        op_a     = (state_reg == H_CROSS_A) ? id_reg[ID_W-1:HALF_W] : id_reg[HALF_W-1:0];
        op_b     = (state_reg == H_CROSS_B) ? MIX_ID[ID_W-1:HALF_W] : MIX_ID[HALF_W-1:0];
        prod     = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
        cls_prod = {{(ID_W-CLASS_W){1'b0}}, cls_reg} * MIX_CLASS;
        mixed    = acc_reg ^ cacc_reg;
        folded   = mixed ^ (mixed >> FOLD_SHIFT);
    end

    // Step sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        home_next  = home_reg;
        id_next    = id_reg;
        cls_next   = cls_reg;
        acc_next   = acc_reg;
        cacc_next  = cacc_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    id_next    = ident;
                    cls_next   = cls;
                    state_next = H_LOW;
                end
            end
            H_LOW:
            begin
                acc_next   = prod;
                cacc_next  = cls_prod;
                state_next = H_CROSS_A;
            end
            H_CROSS_A:
            begin
                acc_next   = {acc_reg[ID_W-1:HALF_W] + prod[HALF_W-1:0], acc_reg[HALF_W-1:0]};
                state_next = H_CROSS_B;
            end
            H_CROSS_B:
            begin
                acc_next   = {acc_reg[ID_W-1:HALF_W] + prod[HALF_W-1:0], acc_reg[HALF_W-1:0]};
                state_next = H_FOLD;
            end
            H_FOLD:
            begin
                home_next  = folded[IDX_W-1:0];
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            home_reg  <= home_next;
            id_reg    <= id_next;
            cls_reg   <= cls_next;
            acc_reg   <= acc_next;
            cacc_reg  <= cacc_next;
        end
    end

    assign done = done_reg;
    assign home = home_reg;

    // A new key never arrives while a hash is still in flight
    `HIR_ASSERT_ALWAYS(a_start_when_idle, clk, start |-> (state_reg == H_IDLE),
        "hash started while busy")

endmodule

`default_nettype wire

@@ sv/hir_ctrl.sv @@
// Request controller: clearing pass, probe walk over the slot memory, updates.
// Depends on hir_pkg; drives hir_hash and hir_ram through the top level.
`default_nettype none

`include "hashed_identity_registry_assert.svh"

module hir_ctrl import hir_pkg::*; #(
    parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request side
    input  wire logic                           req_valid,
    input  wire hir_req_t                       req,
    output logic                                req_ready,
    // hash unit
    output logic                                hash_start,
    input  wire logic                           hash_done,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] hash_home,
    // slot memory
    output logic                                ram_we,
    output logic [$clog2(TABLE_SLOTS)-1:0]      ram_waddr,
    output hir_entry_t                          ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(TABLE_SLOTS)-1:0]      ram_raddr,
    input  wire hir_entry_t                     ram_rdata,
    // result side
    output logic                                res_valid,
    output hir_res_t                            res,
    input  wire logic                           res_ready
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 report_reg, report_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     probe_reg, probe_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [ID_W-1:0]      ident_reg, ident_next;
    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [NUMBER_W-1:0]  number_reg, number_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [NUMBER_W-1:0]  last_reg, last_next;

    logic                 accept;
    logic                 hit;
    logic                 is_resolve;
    logic [CNT_W+COUNT_W-1:0] held_ext, active_ext;

    assign accept     = req_valid && req_ready;
    assign hit        = ram_rdata.used && (ram_rdata.ident == ident_reg)
                        && (ram_rdata.cls == cls_reg);
    assign is_resolve = (kind_reg == KIND_RESOLVE);

    // Next state, memory port control and counter updates
    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        kind_next   = kind_reg;
        ident_next  = ident_reg;
        cls_next    = cls_reg;
        status_next = status_reg;
        number_next = number_reg;
        held_next   = held_reg;
        active_next = active_reg;
        last_next   = last_reg;

        hash_start  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = hash_home;

        case (state_reg)
            // Clearing pass: one slot per cycle marked unused
            S_WIPE:
            begin
                ram_we = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = report_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = req.kind;
                    ident_next  = req.ident;
                    cls_next    = req.cls;
                    number_next = '0;
                    case (req.kind)
                        KIND_CLEAR:
                        begin
                            held_next   = '0;
                            active_next = '0;
                            last_next   = '0;
                            idx_next    = '0;
                            report_next = 1'b1;
                            status_next = ST_CLEARED;
                            state_next  = S_WIPE;
                        end
                        KIND_RESOLVE, KIND_RETIRE:
                        begin
                            if (req.key_ok)
                            begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                            else
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // Wait for the home slot, then read it
            S_HASH:
            begin
                if (hash_done)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = hash_home;
                    idx_next   = hash_home;
                    probe_next = '0;
                    state_next = S_PROBE;
                end
            end

            // One slot checked per cycle; the next read is issued on a miss
            S_PROBE:
            begin
                if (!ram_rdata.used)
                begin
                    // key absent, this is also the first free slot from home
                    state_next = S_DONE;
                    if (!is_resolve)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (&last_reg)
                    begin
                        status_next = ST_COUNTER_OUT;
                    end
                    else
                    begin
                        ram_we            = 1'b1;
                        ram_wdata.used    = 1'b1;
                        ram_wdata.retired = 1'b0;
                        ram_wdata.number  = last_reg + NUMBER_W'(1);
                        ram_wdata.cls     = cls_reg;
                        ram_wdata.ident   = ident_reg;
                        last_next   = last_reg + NUMBER_W'(1);
                        held_next   = held_reg + CNT_W'(1);
                        active_next = active_reg + CNT_W'(1);
                        status_next = ST_ALLOCATED;
                        number_next = last_reg + NUMBER_W'(1);
                    end
                end
                else if (hit)
                begin
                    state_next = S_DONE;
                    if (is_resolve)
                    begin
                        status_next = ram_rdata.retired ? ST_ALREADY_RETIRED : ST_EXISTING;
                        number_next = ram_rdata.number;
                    end
                    else if (ram_rdata.retired)
                    begin
                        status_next = ST_ALREADY_RETIRED;
                    end
                    else
                    begin
                        ram_we            = 1'b1;
                        ram_wdata         = ram_rdata;
                        ram_wdata.retired = 1'b1;
                        if (active_reg != '0)
                        begin
                            active_next = active_reg - CNT_W'(1);
                        end
                        status_next = ST_RETIRED;
                    end
                end
                else if (probe_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    // every slot used and none matches
                    state_next  = S_DONE;
                    status_next = is_resolve ? ST_FULL : ST_NOT_FOUND;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg + IDX_W'(1);
                    idx_next   = idx_reg + IDX_W'(1);
                    probe_next = probe_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_WIPE;
            report_reg <= 1'b0;
            idx_reg    <= '0;
            held_reg   <= '0;
            active_reg <= '0;
            last_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
            idx_reg    <= idx_next;
            held_reg   <= held_next;
            active_reg <= active_next;
            last_reg   <= last_next;
            probe_reg  <= probe_next;
            kind_reg   <= kind_next;
            ident_reg  <= ident_next;
            cls_reg    <= cls_next;
            status_reg <= status_next;
            number_reg <= number_next;
        end
    end

    // Counts reported at the fixed output width
    assign held_ext   = {{COUNT_W{1'b0}}, held_reg};
    assign active_ext = {{COUNT_W{1'b0}}, active_reg};

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.number = number_reg;
    assign res.held   = held_ext[COUNT_W-1:0];
    assign res.active = active_ext[COUNT_W-1:0];

    `HIR_ASSERT(a_no_rw_overlap, clk, rst_n, ram_we |-> !ram_re,
        "slot memory read and written in the same cycle")
    `HIR_ASSERT(a_counts_bounded, clk, rst_n,
        (active_reg <= held_reg) && (held_reg <= CNT_W'(TABLE_SLOTS)),
        "slot counts out of range")
    `HIR_ASSERT(a_hash_expected, clk, rst_n, hash_done |-> (state_reg == S_HASH),
        "hash result outside of hash wait")
    `HIR_ASSERT(a_result_held, clk, rst_n,
        (res_valid && !res_ready) |=> (res_valid && $stable(status_reg)),
        "pending result changed before it was taken")

endmodule

`default_nettype wire

@@ sim/hir_registry_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the hashed identity registry: mirrors the key table, predicts
// one result per accepted request and compares it with the result stream.
// Depends on hir_pkg only.

module hir_registry_checker import hir_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // identity[63:0], object_class[71:64]
    input  wire logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,   // entity_number, held, active, zero
    input  wire logic [STATUS_W-1:0]    m_tuser,   // status[3:0]
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output int                          replies_due,
    output int                          failures
);

    localparam int SLOTS = DEFAULT_TABLE_SLOTS;
    localparam bit [ID_W-1:0] SLOT_MASK = ID_W'(SLOTS - 1);

    typedef struct {
        bit [STATUS_W-1:0] status;
        bit [NUMBER_W-1:0] entity;
        bit [COUNT_W-1:0]  held;
        bit [COUNT_W-1:0]  active;
    } reply_t;

    // Mirror of the key table and its counters
    bit [ID_W-1:0]     key_ident   [SLOTS];
    bit [CLASS_W-1:0]  key_cls     [SLOTS];
    bit [NUMBER_W-1:0] key_entity  [SLOTS];
    bit                key_used    [SLOTS];
    bit                key_retired [SLOTS];
    int                keys_held;
    int                keys_active;
    bit [NUMBER_W-1:0] entity_counter;
    bit [CFG_W-1:0]    class_min;
    bit [CFG_W-1:0]    class_max;

    reply_t awaited_replies [$];
    reply_t oldest;

    // Multiply-xor hash folded down to a slot index
    function automatic int home_slot(bit [ID_W-1:0] ident, bit [CLASS_W-1:0] cls);
        bit [ID_W-1:0] mix;
        mix = (ident * MIX_ID) ^ (ID_W'(cls) * MIX_CLASS);
        return int'((mix ^ (mix >> FOLD_SHIFT)) & SLOT_MASK);
    endfunction

    // Slot holding the key, -1 when the probe run ends without it
    function automatic int find_key(bit [ID_W-1:0] ident, bit [CLASS_W-1:0] cls);
        int idx;
        idx = home_slot(ident, cls);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!key_used[idx])
                return -1;
            if (key_ident[idx] == ident && key_cls[idx] == cls)
                return idx;
            idx = (idx + 1) & (SLOTS - 1);
        end
        return -1;
    endfunction

    // First free slot from the home slot, -1 when the table is packed
    function automatic int find_free(bit [ID_W-1:0] ident, bit [CLASS_W-1:0] cls);
        int idx;
        idx = home_slot(ident, cls);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!key_used[idx])
                return idx;
            idx = (idx + 1) & (SLOTS - 1);
        end
        return -1;
    endfunction

    function automatic void empty_registry();
        for (int n = 0; n < SLOTS; n++)
        begin
            key_used[n]    = 1'b0;
            key_retired[n] = 1'b0;
        end
        keys_held      = 0;
        keys_active    = 0;
        entity_counter = '0;
    endfunction

    // Applies one request to the mirror and returns the result it must give
    function automatic reply_t registry_outcome(bit [KIND_W-1:0] kind, bit [ID_W-1:0] ident,
                                                bit [CLASS_W-1:0] cls);
        reply_t r;
        int     slot;
        bit     key_ok;
        r.status = ST_INVALID;
        r.entity = '0;
        key_ok = ident != '0 && cls >= class_min && cls <= class_max;
        if (kind == KIND_CLEAR)
        begin
            empty_registry();
            r.status = ST_CLEARED;
        end
        else if (kind == KIND_RESOLVE && key_ok)
        begin
            slot = find_key(ident, cls);
            if (slot >= 0)
            begin
                r.status = key_retired[slot] ? ST_ALREADY_RETIRED : ST_EXISTING;
                r.entity = key_entity[slot];
            end
            else if (keys_held >= SLOTS)
                r.status = ST_FULL;
            else if (entity_counter == '1)
                r.status = ST_COUNTER_OUT;
            else
            begin
                slot = find_free(ident, cls);
                if (slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    entity_counter    = entity_counter + 1;
                    key_ident[slot]   = ident;
                    key_cls[slot]     = cls;
                    key_entity[slot]  = entity_counter;
                    key_used[slot]    = 1'b1;
                    key_retired[slot] = 1'b0;
                    keys_held++;
                    keys_active++;
                    r.status = ST_ALLOCATED;
                    r.entity = entity_counter;
                end
            end
        end
        else if (kind == KIND_RETIRE && key_ok)
        begin
            slot = find_key(ident, cls);
            if (slot < 0)
                r.status = ST_NOT_FOUND;
            else if (key_retired[slot])
                r.status = ST_ALREADY_RETIRED;
            else
            begin
                key_retired[slot] = 1'b1;
                if (keys_active > 0)
                    keys_active--;
                r.status = ST_RETIRED;
            end
        end
        r.held   = COUNT_W'(keys_held);
        r.active = COUNT_W'(keys_active);
        return r;
    endfunction

    function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            failures++;
        end
    endfunction

    // Track register writes, requests and results at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_registry();
            class_min = TYPE_LOWEST_RESET;
            class_max = TYPE_HIGHEST_RESET;
            awaited_replies.delete();
            replies_due <= 0;
            failures = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TYPE_LOWEST)
                    class_min = cfg_data;
                else if (cfg_index == CFG_TYPE_HIGHEST)
                    class_max = cfg_data;
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(registry_outcome(s_tuser, s_tdata[ID_W-1:0],
                                                           s_tdata[ID_W +: CLASS_W]));
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unrequested result, expected none, actual status %0h",
                             $time, m_tuser);
                    failures++;
                end
                else
                begin
                    oldest = awaited_replies.pop_front();
                    check_field("status", 64'(oldest.status), 64'(m_tuser));
                    check_field("entity_number", oldest.entity, m_tdata[NUMBER_W-1:0]);
                    check_field("identities_held", 64'(oldest.held),
                                64'(m_tdata[NUMBER_W +: COUNT_W]));
                    check_field("identities_active", 64'(oldest.active),
                                64'(m_tdata[NUMBER_W+COUNT_W +: COUNT_W]));
                    check_field("tdata padding", 64'd0, 64'(m_tdata[M_TDATA_W-1 -: M_PAD_W]));
                end
            end
            replies_due <= awaited_replies.size();
        end
    end

endmodule

@@ sim/tb_hashed_identity_registry.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the hashed identity registry: directed and random
// resolve, retire and clear requests over several type ranges, a full table,
// random stalls on both sides. Depends on hir_pkg and hir_registry_checker.

module tb_hashed_identity_registry;
    import hir_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int POOL_SIZE  = 48;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 20000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // identity[63:0], object_class[71:64]
    logic [KIND_W-1:0]      s_tuser   = '0;   // kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // entity_number, held, active, zero
    logic [STATUS_W-1:0]    m_tuser;          // status[3:0]
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    int replies_due;
    int failures;

    // Traffic shaping shared by sender and receiver
    bit calm      = 1'b0;
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Recent keys, reused so that lookups and retires hit stored entries
    bit [ID_W-1:0]    pool_ident [POOL_SIZE];
    bit [CLASS_W-1:0] pool_cls   [POOL_SIZE];
    bit [CFG_W-1:0]   cur_lo = TYPE_LOWEST_RESET;
    bit [CFG_W-1:0]   cur_hi = TYPE_HIGHEST_RESET;

    bit [CFG_W-1:0] phase_lo  [6] = '{8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd10};
    bit [CFG_W-1:0] phase_hi  [6] = '{8'd7, 8'd255, 8'd0, 8'd255, 8'd255, 8'd3};
    int             phase_len [6] = '{30, 30, 30, 30, 20, 15};

    hashed_identity_registry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hir_registry_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .replies_due (replies_due),
        .failures    (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            m_tready  <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD - 1;
        end
        else
            m_tready <= calm || ($urandom_range(99, 0) >= 12);
    end

    // Watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one request, after a random gap unless calm, and wait until it is taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ident,
                                input logic [CLASS_W-1:0] cls);
        if (!calm)
        begin
            while ($urandom_range(99, 0) < 12)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {cls, ident};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and let every pending result come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write both type-range registers, block idle
    task automatic set_limits(input bit [CFG_W-1:0] lo, input bit [CFG_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TYPE_LOWEST;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_TYPE_HIGHEST;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Mostly known keys and valid classes, with some noise
    task automatic random_request();
        int                 roll;
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    ident;
        logic [CLASS_W-1:0] cls;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            kind = KIND_RESOLVE;
        else if (roll < 90)
            kind = KIND_RETIRE;
        else if (roll < 93)
            kind = KIND_CLEAR;
        else
            kind = KIND_UNUSED;
        if ($urandom_range(99, 0) < 60)
        begin
            pick  = $urandom_range(POOL_SIZE - 1, 0);
            ident = pool_ident[pick];
            cls   = pool_cls[pick];
        end
        else
        begin
            ident = {$urandom, $urandom};
            if ($urandom_range(49, 0) == 0)
                ident = '0;
            if (cur_lo <= cur_hi && $urandom_range(99, 0) < 85)
                cls = CLASS_W'($urandom_range(cur_hi, cur_lo));
            else
                cls = CLASS_W'($urandom_range(255, 0));
            pick = $urandom_range(POOL_SIZE - 1, 0);
            pool_ident[pick] = ident;
            pool_cls[pick]   = cls;
        end
        send_request(kind, ident, cls);
    endtask

    initial
    begin
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_ident[k] = {$urandom, $urandom} | 64'd1;
            pool_cls[k]   = CLASS_W'($urandom_range(7, 0));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: each status but full and counter out, under the reset type range
        send_request(KIND_RESOLVE, 64'd1, 8'd0);
        send_request(KIND_RESOLVE, 64'd1, 8'd0);
        send_request(KIND_RESOLVE, '1, 8'd7);
        send_request(KIND_RETIRE, 64'd1, 8'd0);
        send_request(KIND_RETIRE, 64'd1, 8'd0);
        send_request(KIND_RESOLVE, 64'd1, 8'd0);
        send_request(KIND_RETIRE, 64'd5, 8'd3);
        send_request(KIND_RESOLVE, 64'd0, 8'd2);
        send_request(KIND_RETIRE, 64'd0, 8'd2);
        send_request(KIND_RESOLVE, 64'd9, 8'd8);
        send_request(KIND_UNUSED, 64'd1, 8'd0);
        send_request(KIND_CLEAR, '1, 8'd255);
        send_request(KIND_RESOLVE, 64'd1, 8'd0);
        send_request(KIND_RESOLVE, 64'h8000_0000_0000_0000, 8'd0);

        // Directed: class below the lowest, inverted range, single class
        wait_drained();
        set_limits(8'd255, 8'd255);
        send_request(KIND_RESOLVE, '1, 8'd255);
        send_request(KIND_RESOLVE, '1, 8'd254);
        send_request(KIND_RESOLVE, 64'd1, 8'd0);
        wait_drained();
        set_limits(8'd200, 8'd100);
        send_request(KIND_RESOLVE, 64'd9, 8'd150);
        send_request(KIND_RETIRE, 64'd9, 8'd150);
        wait_drained();
        set_limits(8'd0, 8'd0);
        send_request(KIND_RESOLVE, 64'd3, 8'd0);
        send_request(KIND_RESOLVE, 64'd3, 8'd1);

        // Random phases over several type ranges
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            set_limits(phase_lo[p], phase_hi[p]);
            calm <= (p == 1);
            for (int n = 0; n < phase_len[p]; n++)
            begin
                if (p == 2 && n == 10)
                    hold_req <= hold_req + 1;
                random_request();
            end
        end

        // Fill the table past capacity with fresh keys, then work on the full table
        wait_drained();
        calm <= 1'b0;
        set_limits(8'd0, 8'd255);
        send_request(KIND_CLEAR, 64'd0, 8'd0);
        for (int n = 0; n < 1030; n++)
        begin
            pool_ident[n % POOL_SIZE] = {$urandom, $urandom} | 64'd1;
            pool_cls[n % POOL_SIZE]   = CLASS_W'($urandom_range(255, 0));
            send_request(KIND_RESOLVE, pool_ident[n % POOL_SIZE], pool_cls[n % POOL_SIZE]);
        end
        for (int n = 0; n < 20; n++)
            random_request();

        // Back to the reset range on an empty table
        wait_drained();
        set_limits(TYPE_LOWEST_RESET, TYPE_HIGHEST_RESET);
        send_request(KIND_CLEAR, 64'd0, 8'd0);
        for (int n = 0; n < 20; n++)
            random_request();

        wait_drained();
        repeat (40) @(posedge clk);
        if (failures == 0 && replies_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
